@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold while out of reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// trig at one edge requires expr at the next edge
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

@@ hdl/bncc_pkg.sv @@
package bncc_pkg;

  localparam int CENTER_W   = 14;
  localparam int TOL_W      = 15;
  localparam int DIST_W     = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int FIFO_DEPTH = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = 15'd32767;
  localparam logic [TOL_W-1:0]  TOL_RESET = 15'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

  typedef struct packed {
    logic [DIST_W-1:0] distance_q;
    logic              near_center;
  } result_t;

endpackage

@@ hdl/bncc_extremes.sv @@
module bncc_extremes #(
  parameter int COORD_BITS = 12,
  localparam int SUM_W = COORD_BITS + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  last_point,
  output logic                  sum_valid,
  output logic [SUM_W-1:0]      sum_x,
  output logic [SUM_W-1:0]      sum_y
);
  import bncc_pkg::*;

  logic [COORD_BITS-1:0] left_x, left_y, right_x, right_y;
  logic [COORD_BITS-1:0] top_x, top_y, bottom_x, bottom_y;
  logic [COORD_BITS-1:0] left_x_next, left_y_next, right_x_next, right_y_next;
  logic [COORD_BITS-1:0] top_x_next, top_y_next, bottom_x_next, bottom_y_next;
  logic                  expect_first;
  logic [SUM_W-1:0]      sum_x_next, sum_y_next;

  always_comb begin
    left_x_next   = left_x;
    left_y_next   = left_y;
    right_x_next  = right_x;
    right_y_next  = right_y;
    top_x_next    = top_x;
    top_y_next    = top_y;
    bottom_x_next = bottom_x;
    bottom_y_next = bottom_y;
    if (expect_first) begin
      left_x_next   = point_x;
      left_y_next   = point_y;
      right_x_next  = point_x;
      right_y_next  = point_y;
      top_x_next    = point_x;
      top_y_next    = point_y;
      bottom_x_next = point_x;
      bottom_y_next = point_y;
    end else begin
      if (point_x > right_x) begin
        right_x_next = point_x;
        right_y_next = point_y;
      end
      if (point_x < left_x) begin
        left_x_next = point_x;
        left_y_next = point_y;
      end
      if (point_y > bottom_y) begin
        bottom_x_next = point_x;
        bottom_y_next = point_y;
      end
      if (point_y < top_y) begin
        top_x_next = point_x;
        top_y_next = point_y;
      end
    end
    sum_x_next = SUM_W'(left_x_next) + SUM_W'(right_x_next)
               + SUM_W'(top_x_next) + SUM_W'(bottom_x_next);
    sum_y_next = SUM_W'(left_y_next) + SUM_W'(right_y_next)
               + SUM_W'(top_y_next) + SUM_W'(bottom_y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_first <= 1'b1;
      sum_valid    <= 1'b0;
      left_x       <= '0;
      left_y       <= '0;
      right_x      <= '0;
      right_y      <= '0;
      top_x        <= '0;
      top_y        <= '0;
      bottom_x     <= '0;
      bottom_y     <= '0;
    end else begin
      sum_valid <= accept && last_point;
      if (accept) begin
        expect_first <= last_point;
        left_x       <= left_x_next;
        left_y       <= left_y_next;
        right_x      <= right_x_next;
        right_y      <= right_y_next;
        top_x        <= top_x_next;
        top_y        <= top_y_next;
        bottom_x     <= bottom_x_next;
        bottom_y     <= bottom_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_point) begin
      sum_x <= sum_x_next;
      sum_y <= sum_y_next;
    end
  end

endmodule

@@ hdl/bncc_distance.sv @@
module bncc_distance #(
  parameter int COORD_BITS = 12,
  localparam int SUM_W = COORD_BITS + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sum_valid,
  input  logic [SUM_W-1:0]               sum_x,
  input  logic [SUM_W-1:0]               sum_y,
  input  logic [bncc_pkg::CENTER_W-1:0]  center_x_q,
  input  logic [bncc_pkg::CENTER_W-1:0]  center_y_q,
  input  logic [bncc_pkg::TOL_W-1:0]     tolerance_q,
  output logic                           diff_valid,
  output logic                           result_valid,
  output bncc_pkg::result_t              result
);
  import bncc_pkg::*;

  localparam int DIFF_W = (SUM_W > CENTER_W) ? SUM_W : CENTER_W;
  localparam int ACC_W  = DIFF_W + 1;

  logic [DIFF_W-1:0] ext_sx, ext_sy, ext_cx, ext_cy;
  logic [DIFF_W-1:0] diff_x, diff_y, diff_x_next, diff_y_next;
  logic [ACC_W-1:0]  dist_full;
  logic [DIST_W-1:0] dist_sat;
  result_t           result_next;

  always_comb begin
    ext_sx = DIFF_W'(sum_x);
    ext_sy = DIFF_W'(sum_y);
    ext_cx = DIFF_W'(center_x_q);
    ext_cy = DIFF_W'(center_y_q);
    diff_x_next = (ext_sx > ext_cx) ? ext_sx - ext_cx : ext_cx - ext_sx;
    diff_y_next = (ext_sy > ext_cy) ? ext_sy - ext_cy : ext_cy - ext_sy;
  end

  always_comb begin
    dist_full = ACC_W'(diff_x) + ACC_W'(diff_y);
    if (dist_full > ACC_W'(DIST_MAX)) begin
      dist_sat = DIST_MAX;
    end else begin
      dist_sat = dist_full[DIST_W-1:0];
    end
    result_next.distance_q  = dist_sat;
    result_next.near_center = (dist_sat < tolerance_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      diff_valid   <= sum_valid;
      result_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid) begin
      diff_x <= diff_x_next;
      diff_y <= diff_y_next;
    end
    if (diff_valid) begin
      result <= result_next;
    end
  end

endmodule

@@ hdl/bncc_result_fifo.sv @@
module bncc_result_fifo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  bncc_pkg::result_t                    wr_data,
  input  logic                                 rd_en,
  output bncc_pkg::result_t                    rd_data,
  output logic                                 not_empty,
  output logic [$clog2(bncc_pkg::FIFO_DEPTH):0] count
);
  import bncc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  result_t           mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;

  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hdl/blob_near_center_check_top.sv @@
// A last point's sums, differences and result are registered, then queued to m_tdata.
// Throughput: one point per cycle while s_tready is high; the extreme
// compare-update is a single stage. Points are refused only when the eight-entry
// result queue's count plus up to three pipeline results reaches its depth.
// Reset (rst, synchronous): clears queue, pipeline valids and extremes; center 0,
// tolerance 120; the next point starts a new region.
module blob_near_center_check_top #(
  parameter int COORD_BITS = 12,
  localparam int S_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [S_DATA_W-1:0]               s_tdata,  // point_x, point_y, zero pad
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // near_center, distance_q
  input  logic                              cfg_we,
  input  logic [bncc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bncc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bncc_pkg::*;

  localparam int SUM_W = COORD_BITS + 2;
  localparam int CNT_W = $clog2(FIFO_DEPTH) + 1;

  logic [CENTER_W-1:0] center_x_q, center_y_q;
  logic [TOL_W-1:0]    tolerance_q;

  logic              accept;
  logic              sum_valid, diff_valid, result_valid;
  logic [SUM_W-1:0]  sum_x, sum_y;
  result_t           result, fifo_out;
  logic              fifo_rd;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W-1:0]  pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_q  <= '0;
      center_y_q  <= '0;
      tolerance_q <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:  center_x_q  <= cfg_data[CENTER_W-1:0];
        CFG_CENTER_Y:  center_y_q  <= cfg_data[CENTER_W-1:0];
        CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
        default:       ;
      endcase
    end
  end

  assign pending  = fifo_count + CNT_W'(sum_valid) + CNT_W'(diff_valid)
                  + CNT_W'(result_valid);
  assign s_tready = (pending < CNT_W'(FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign fifo_rd  = m_tvalid && m_tready;
  assign m_tdata  = fifo_out;

  bncc_extremes #(
    .COORD_BITS (COORD_BITS)
  ) u_extremes (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .point_x    (s_tdata[COORD_BITS-1:0]),
    .point_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .last_point (s_tlast),
    .sum_valid  (sum_valid),
    .sum_x      (sum_x),
    .sum_y      (sum_y)
  );

  bncc_distance #(
    .COORD_BITS (COORD_BITS)
  ) u_distance (
    .clk          (clk),
    .rst          (rst),
    .sum_valid    (sum_valid),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .center_x_q   (center_x_q),
    .center_y_q   (center_y_q),
    .tolerance_q  (tolerance_q),
    .diff_valid   (diff_valid),
    .result_valid (result_valid),
    .result       (result)
  );

  bncc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (result_valid),
    .wr_data   (result),
    .rd_en     (fifo_rd),
    .rd_data   (fifo_out),
    .not_empty (m_tvalid),
    .count     (fifo_count)
  );

`include "assert_macros.svh"

  `ASSERT_NEVER(a_fifo_overflow, result_valid && !fifo_rd && (fifo_count == CNT_W'(FIFO_DEPTH)), "result queue overflow")
  `ASSERT_NEXT(a_last_starts_result, accept && s_tlast, sum_valid, "last point did not start a result")
  `ASSERT_NEXT(a_no_spurious_result, !(accept && s_tlast), !sum_valid, "result without a last point")
  `ASSERT_NEXT(a_result_follows, sum_valid, diff_valid, "pipeline dropped a result")

endmodule
